@@ hw/rtl/indexed_binary_heap_top_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef INDEXED_BINARY_HEAP_TOP_MACROS_SVH
`define INDEXED_BINARY_HEAP_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IBH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap check failed");
`define IBH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap sequencing check failed");
`else
`define IBH_ASSERT_IMPL(lbl, ante, cons)
`define IBH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/ibh_pkg.sv @@
package ibh_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_POP      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_REMAT    = 3'd3,
        CMD_UPDATE   = 3'd4,
        CMD_REMKEY   = 3'd5,
        CMD_CONTAINS = 3'd6,
        CMD_LOCATE   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

endpackage

@@ hw/rtl/ibh_core.sv @@
module ibh_core #(
    parameter int CAPACITY  = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibh_pkg::KEY_WIDTH_DEF,
    parameter int IDW       = $clog2(ibh_pkg::CAPACITY_DEF + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  max_first,
    input  logic                  start,
    input  ibh_pkg::cmd_t         cmd,
    input  logic [KEY_WIDTH-1:0]  key_in,
    input  logic [IDW-1:0]        item_id,
    input  logic [IDW-1:0]        heap_position,
    input  logic                  out_free,
    output logic                  idle,
    output logic                  done,
    output ibh_pkg::status_t      status,
    output logic [KEY_WIDTH-1:0]  key_out,
    output logic [IDW-1:0]        id_out,
    output logic [IDW-1:0]        position_out,
    output logic [IDW-1:0]        count_out
);
    import ibh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW = IDW + 1;
    localparam int HW = KEY_WIDTH + IDW;
    localparam logic [IDW-1:0] CAP_V = IDW'(CAPACITY);
    localparam logic [AW-1:0]  LAST_A = AW'(CAPACITY - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_WAIT, S_INS_CHK, S_TAKE, S_REM, S_REM_LAST, S_UPD,
        S_SCAN, S_LOC, S_UP, S_UP_CMP, S_DN_LOAD, S_DN_GOT, S_DN, S_DN_L,
        S_DN_R, S_DN_CMP, S_FIN
    } state_t;

    // Slot store: {id, key} per slot; map store: slot per id.
    logic [HW-1:0]  hmem [CAPACITY];
    logic [IDW-1:0] mmem [CAPACITY];

    logic           hm_we_reg, mp_we_reg;
    logic [AW-1:0]  hm_wa_reg, hm_ra_reg, mp_wa_reg, mp_ra_reg;
    logic [HW-1:0]  hm_wd_reg, hm_q_reg;
    logic [IDW-1:0] mp_wd_reg, mp_q_reg;

    state_t             st_reg, ret_reg;
    cmd_t               cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg, e_key_reg, c_key_reg, key_o_reg;
    logic [IDW-1:0]     id_reg, e_id_reg, c_id_reg, id_o_reg, pos_o_reg;
    logic [IDW-1:0]     cnt_reg, orig_reg, scan_reg;
    logic [SW-1:0]      slot_reg, c_slot_reg;
    logic [AW-1:0]      clr_reg;
    logic               down_reg, done_reg;
    status_t            status_reg;

    logic [KEY_WIDTH-1:0] q_key;
    logic [IDW-1:0]       q_id;
    logic [SW-1:0]        cnt_w, left_w, right_w;

    function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s - SW'(1);
        return t[AW-1:0];
    endfunction

    function automatic logic better(input logic [KEY_WIDTH-1:0] a,
                                    input logic [KEY_WIDTH-1:0] b,
                                    input logic mx);
        return mx ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    assign q_key   = hm_q_reg[KEY_WIDTH-1:0];
    assign q_id    = hm_q_reg[HW-1:KEY_WIDTH];
    assign cnt_w   = {1'b0, cnt_reg};
    assign left_w  = {slot_reg[SW-2:0], 1'b0};
    assign right_w = {slot_reg[SW-2:0], 1'b1};

    always_ff @(posedge clk)
    begin
        if (hm_we_reg)
        begin
            hmem[hm_wa_reg] <= hm_wd_reg;
        end
        hm_q_reg <= hmem[hm_ra_reg];
        if (mp_we_reg)
        begin
            mmem[mp_wa_reg] <= mp_wd_reg;
        end
        mp_q_reg <= mmem[mp_ra_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLEAR;
            ret_reg    <= S_IDLE;
            cmd_reg    <= CMD_INSERT;
            key_reg    <= '0;
            id_reg     <= '0;
            e_key_reg  <= '0;
            e_id_reg   <= '0;
            c_key_reg  <= '0;
            c_id_reg   <= '0;
            c_slot_reg <= '0;
            key_o_reg  <= '0;
            id_o_reg   <= '0;
            pos_o_reg  <= '0;
            cnt_reg    <= '0;
            orig_reg   <= '0;
            scan_reg   <= '0;
            slot_reg   <= '0;
            clr_reg    <= '0;
            down_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            hm_we_reg  <= 1'b0;
            hm_wa_reg  <= '0;
            hm_wd_reg  <= '0;
            hm_ra_reg  <= '0;
            mp_we_reg  <= 1'b0;
            mp_wa_reg  <= '0;
            mp_wd_reg  <= '0;
            mp_ra_reg  <= '0;
        end
        else
        begin
            hm_we_reg <= 1'b0;
            mp_we_reg <= 1'b0;
            done_reg  <= 1'b0;
            case (st_reg)
                S_CLEAR:
                begin
                    mp_we_reg <= 1'b1;
                    mp_wa_reg <= clr_reg;
                    mp_wd_reg <= '0;
                    if (clr_reg == LAST_A)
                    begin
                        st_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg    <= cmd;
                        key_reg    <= key_in;
                        id_reg     <= item_id;
                        status_reg <= ST_OK;
                        key_o_reg  <= '0;
                        id_o_reg   <= '0;
                        pos_o_reg  <= '0;
                        st_reg     <= S_WAIT;
                        case (cmd)
                            CMD_INSERT:
                            begin
                                if (cnt_reg == CAP_V)
                                begin
                                    status_reg <= ST_FULL;
                                    st_reg     <= S_FIN;
                                end
                                else if (item_id == '0 || item_id > CAP_V)
                                begin
                                    status_reg <= ST_BADPOS;
                                    st_reg     <= S_FIN;
                                end
                                else
                                begin
                                    mp_ra_reg <= to_addr({1'b0, item_id});
                                    ret_reg   <= S_INS_CHK;
                                end
                            end
                            CMD_POP, CMD_PEEK:
                            begin
                                if (cnt_reg == '0)
                                begin
                                    status_reg <= ST_EMPTY;
                                    st_reg     <= S_FIN;
                                end
                                else
                                begin
                                    hm_ra_reg <= '0;
                                    slot_reg  <= SW'(1);
                                    ret_reg   <= S_TAKE;
                                end
                            end
                            CMD_REMAT, CMD_UPDATE:
                            begin
                                if (heap_position == '0 || heap_position > cnt_reg)
                                begin
                                    status_reg <= ST_BADPOS;
                                    st_reg     <= S_FIN;
                                end
                                else
                                begin
                                    hm_ra_reg <= to_addr({1'b0, heap_position});
                                    slot_reg  <= {1'b0, heap_position};
                                    ret_reg   <= (cmd == CMD_REMAT) ? S_TAKE : S_UPD;
                                end
                            end
                            CMD_REMKEY, CMD_CONTAINS:
                            begin
                                status_reg <= ST_EMPTY;
                                if (cnt_reg == '0)
                                begin
                                    st_reg <= S_FIN;
                                end
                                else
                                begin
                                    hm_ra_reg <= '0;
                                    scan_reg  <= IDW'(1);
                                    ret_reg   <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                if (item_id == '0 || item_id > CAP_V)
                                begin
                                    status_reg <= ST_EMPTY;
                                    st_reg     <= S_FIN;
                                end
                                else
                                begin
                                    mp_ra_reg <= to_addr({1'b0, item_id});
                                    ret_reg   <= S_LOC;
                                end
                            end
                        endcase
                    end
                end
                S_WAIT:
                begin
                    st_reg <= ret_reg;
                end
                S_INS_CHK:
                begin
                    if (mp_q_reg != '0)
                    begin
                        status_reg <= ST_BADPOS;
                        st_reg     <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + IDW'(1);
                        slot_reg  <= cnt_w + SW'(1);
                        e_key_reg <= key_reg;
                        e_id_reg  <= id_reg;
                        down_reg  <= 1'b0;
                        st_reg    <= S_UP;
                    end
                end
                S_TAKE:
                begin
                    key_o_reg <= q_key;
                    id_o_reg  <= q_id;
                    st_reg    <= (cmd_reg == CMD_PEEK) ? S_FIN : S_REM;
                end
                S_REM:
                begin
                    mp_we_reg <= 1'b1;
                    mp_wa_reg <= to_addr({1'b0, id_o_reg});
                    mp_wd_reg <= '0;
                    if (slot_reg < cnt_w)
                    begin
                        hm_ra_reg <= to_addr(cnt_w);
                        ret_reg   <= S_REM_LAST;
                        st_reg    <= S_WAIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - IDW'(1);
                        st_reg  <= S_FIN;
                    end
                end
                S_REM_LAST:
                begin
                    e_key_reg <= q_key;
                    e_id_reg  <= q_id;
                    cnt_reg   <= cnt_reg - IDW'(1);
                    orig_reg  <= slot_reg[IDW-1:0];
                    down_reg  <= 1'b1;
                    st_reg    <= S_UP;
                end
                S_UPD:
                begin
                    e_key_reg <= key_reg;
                    e_id_reg  <= q_id;
                    orig_reg  <= slot_reg[IDW-1:0];
                    down_reg  <= 1'b1;
                    st_reg    <= S_UP;
                end
                S_SCAN:
                begin
                    if (q_key == key_reg)
                    begin
                        status_reg <= ST_OK;
                        if (cmd_reg == CMD_CONTAINS)
                        begin
                            st_reg <= S_FIN;
                        end
                        else
                        begin
                            key_o_reg <= q_key;
                            id_o_reg  <= q_id;
                            slot_reg  <= {1'b0, scan_reg};
                            st_reg    <= S_REM;
                        end
                    end
                    else if (scan_reg == cnt_reg)
                    begin
                        st_reg <= S_FIN;
                    end
                    else
                    begin
                        scan_reg  <= scan_reg + IDW'(1);
                        hm_ra_reg <= to_addr({1'b0, scan_reg} + SW'(1));
                        ret_reg   <= S_SCAN;
                        st_reg    <= S_WAIT;
                    end
                end
                S_LOC:
                begin
                    pos_o_reg  <= mp_q_reg;
                    status_reg <= (mp_q_reg != '0) ? ST_OK : ST_EMPTY;
                    st_reg     <= S_FIN;
                end
                // The moving entry is held in registers; its slot is written
                // once it settles, parents move down into the hole meanwhile.
                S_UP:
                begin
                    if (slot_reg > SW'(1))
                    begin
                        hm_ra_reg <= to_addr(slot_reg >> 1);
                        ret_reg   <= S_UP_CMP;
                        st_reg    <= S_WAIT;
                    end
                    else
                    begin
                        hm_we_reg <= 1'b1;
                        hm_wa_reg <= to_addr(slot_reg);
                        hm_wd_reg <= {e_id_reg, e_key_reg};
                        mp_we_reg <= 1'b1;
                        mp_wa_reg <= to_addr({1'b0, e_id_reg});
                        mp_wd_reg <= slot_reg[IDW-1:0];
                        st_reg    <= down_reg ? S_DN_LOAD : S_FIN;
                    end
                end
                S_UP_CMP:
                begin
                    hm_we_reg <= 1'b1;
                    hm_wa_reg <= to_addr(slot_reg);
                    mp_we_reg <= 1'b1;
                    mp_wd_reg <= slot_reg[IDW-1:0];
                    if (better(e_key_reg, q_key, max_first))
                    begin
                        hm_wd_reg <= hm_q_reg;
                        mp_wa_reg <= to_addr({1'b0, q_id});
                        slot_reg  <= slot_reg >> 1;
                        st_reg    <= S_UP;
                    end
                    else
                    begin
                        hm_wd_reg <= {e_id_reg, e_key_reg};
                        mp_wa_reg <= to_addr({1'b0, e_id_reg});
                        st_reg    <= down_reg ? S_DN_LOAD : S_FIN;
                    end
                end
                // Sift-down restarts from the original slot with what it now holds.
                S_DN_LOAD:
                begin
                    hm_ra_reg <= to_addr({1'b0, orig_reg});
                    slot_reg  <= {1'b0, orig_reg};
                    ret_reg   <= S_DN_GOT;
                    st_reg    <= S_WAIT;
                end
                S_DN_GOT:
                begin
                    e_key_reg <= q_key;
                    e_id_reg  <= q_id;
                    st_reg    <= S_DN;
                end
                S_DN:
                begin
                    if (left_w > cnt_w)
                    begin
                        hm_we_reg <= 1'b1;
                        hm_wa_reg <= to_addr(slot_reg);
                        hm_wd_reg <= {e_id_reg, e_key_reg};
                        mp_we_reg <= 1'b1;
                        mp_wa_reg <= to_addr({1'b0, e_id_reg});
                        mp_wd_reg <= slot_reg[IDW-1:0];
                        st_reg    <= S_FIN;
                    end
                    else
                    begin
                        hm_ra_reg <= to_addr(left_w);
                        ret_reg   <= S_DN_L;
                        st_reg    <= S_WAIT;
                    end
                end
                S_DN_L:
                begin
                    c_slot_reg <= left_w;
                    c_key_reg  <= q_key;
                    c_id_reg   <= q_id;
                    if (right_w <= cnt_w)
                    begin
                        hm_ra_reg <= to_addr(right_w);
                        ret_reg   <= S_DN_R;
                        st_reg    <= S_WAIT;
                    end
                    else
                    begin
                        st_reg <= S_DN_CMP;
                    end
                end
                S_DN_R:
                begin
                    // On equal children the right one is the candidate.
                    if (!better(c_key_reg, q_key, max_first))
                    begin
                        c_slot_reg <= right_w;
                        c_key_reg  <= q_key;
                        c_id_reg   <= q_id;
                    end
                    st_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    hm_we_reg <= 1'b1;
                    hm_wa_reg <= to_addr(slot_reg);
                    mp_we_reg <= 1'b1;
                    mp_wd_reg <= slot_reg[IDW-1:0];
                    if (better(c_key_reg, e_key_reg, max_first))
                    begin
                        hm_wd_reg <= {c_id_reg, c_key_reg};
                        mp_wa_reg <= to_addr({1'b0, c_id_reg});
                        slot_reg  <= c_slot_reg;
                        st_reg    <= S_DN;
                    end
                    else
                    begin
                        hm_wd_reg <= {e_id_reg, e_key_reg};
                        mp_wa_reg <= to_addr({1'b0, e_id_reg});
                        st_reg    <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle         = (st_reg == S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign key_out      = key_o_reg;
    assign id_out       = id_o_reg;
    assign position_out = pos_o_reg;
    assign count_out    = cnt_reg;

endmodule

@@ hw/rtl/indexed_binary_heap_top.sv @@
// Indexed binary heap priority queue with an id-to-slot map.
// Channels: s_axis carries one command per transfer; m_axis returns exactly one
// result per command; cfg writes the order bit (1 largest on top, 0 smallest).
// Configuration writes are always accepted and should be made while idle.
// After reset the map store is cleared entry by entry, during which
// s_axis_tready stays low; the order bit resets to largest on top.
// One command is worked on at a time. Every access goes through a slot store
// and a map store, each with one write and one registered read per cycle.
// Insert climbs the tree; pop and removals may climb and then descend.
// Remove-key and contains scan slots in order. Results sit in an output
// register; while the receiver stalls, the next command may be accepted and
// worked on, and its result waits until the register is free.
`include "indexed_binary_heap_top_macros.svh"

module indexed_binary_heap_top #(
    parameter int CAPACITY  = ibh_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ibh_pkg::KEY_WIDTH_DEF,
    parameter int IDW       = $clog2(CAPACITY + 1),
    parameter int IN_W      = ((3 + KEY_WIDTH + 2 * IDW + 7) / 8) * 8,
    parameter int OUT_W     = ((2 + KEY_WIDTH + 3 * IDW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd, key_in, item_id, heap_position
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status, key_out, id_out, position_out, count_out
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import ibh_pkg::*;

    localparam int KL = 3;
    localparam int IL = KL + KEY_WIDTH;
    localparam int PL = IL + IDW;
    localparam int RES_W = 2 + KEY_WIDTH + 3 * IDW;

    logic                 max_first_reg;
    logic                 out_valid_reg;
    logic [RES_W-1:0]     out_data_reg;
    logic                 core_idle, core_done, start, out_free;
    status_t              c_status;
    logic [KEY_WIDTH-1:0] c_key;
    logic [IDW-1:0]       c_id, c_pos, c_cnt;

    assign start     = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    ibh_core #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .IDW       (IDW)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .max_first     (max_first_reg),
        .start         (start),
        .cmd           (cmd_t'(s_axis_tdata[KL-1:0])),
        .key_in        (s_axis_tdata[IL-1:KL]),
        .item_id       (s_axis_tdata[PL-1:IL]),
        .heap_position (s_axis_tdata[PL+IDW-1:PL]),
        .out_free      (out_free),
        .idle          (core_idle),
        .done          (core_done),
        .status        (c_status),
        .key_out       (c_key),
        .id_out        (c_id),
        .position_out  (c_pos),
        .count_out     (c_cnt)
    );

    assign s_axis_tready = core_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_first_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_first_reg <= cfg_data;
            end
            if (core_done)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {c_cnt, c_pos, c_id, c_key, c_status};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, out_data_reg};

    logic [1:0]     mon_status;
    logic [IDW-1:0] mon_count;
    assign mon_status = out_data_reg[1:0];
    assign mon_count  = out_data_reg[RES_W-1:RES_W-IDW];

    `IBH_ASSERT_NEXT(a_one_at_a_time, start, !s_axis_tready)
    `IBH_ASSERT_IMPL(a_full_count, out_valid_reg && mon_status == ST_FULL, mon_count == IDW'(CAPACITY))
    `IBH_ASSERT_IMPL(a_count_range, out_valid_reg, mon_count <= IDW'(CAPACITY))
    `IBH_ASSERT_IMPL(a_no_overwrite, core_done, out_free || !out_valid_reg)

endmodule
